// ===== rtl/fpa_pkg.sv =====
package fpa_pkg;

  // Operand and result width
  localparam int DATA_W = 32;

  // Default number of fraction bits (Q24.8)
  localparam int FRACTION_BITS_DEF = 8;

  // Operation codes carried on the mode field
  typedef enum logic [3:0] {
    MODE_ADD      = 4'd0,
    MODE_SUB      = 4'd1,
    MODE_MUL      = 4'd2,
    MODE_DIV      = 4'd3,
    MODE_GT       = 4'd4,
    MODE_LT       = 4'd5,
    MODE_GE       = 4'd6,
    MODE_LE       = 4'd7,
    MODE_EQ       = 4'd8,
    MODE_NE       = 4'd9,
    MODE_MIN      = 4'd10,
    MODE_MAX      = 4'd11,
    MODE_INC      = 4'd12,
    MODE_DEC      = 4'd13,
    MODE_TO_INT   = 4'd14,
    MODE_FROM_INT = 4'd15
  } mode_t;

  // Per-item info that rides alongside the divider chain
  typedef struct packed {
    logic              is_div;  // take the quotient as the result
    logic              dz;      // divide by zero
    logic              neg;     // quotient sign
    logic              cmp;     // comparison outcome
    logic [DATA_W-1:0] res;     // result of every other mode
  } side_t;

endpackage

// ===== rtl/fixed_point_alu_unit.sv =====
// Signed 32-bit fixed-point ALU (FRACTION_BITS fraction bits, default Q24.8)
// covering add, sub, mul, div, six compares, min/max, inc/dec and integer
// conversions. It takes one item per cycle unless the result side stalls. The
// pipeline is one operand stage with the 32x32 multiplier, a chain of
// 32 + FRACTION_BITS division cells that each settle one quotient bit of the
// widened dividend, and one output register. All items run through the full
// chain, so results leave in order. A stall on the result side holds the whole
// pipeline. Divide rounds toward zero and keeps the low 32 bits; divide by zero
// returns 0 with divide_by_zero set.
module fixed_point_alu_unit #(
  parameter int FRACTION_BITS = fpa_pkg::FRACTION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [3:0]                        in_mode,
  input  logic signed [fpa_pkg::DATA_W-1:0] in_operand_a,
  input  logic signed [fpa_pkg::DATA_W-1:0] in_operand_b,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [fpa_pkg::DATA_W-1:0] out_result_value,
  output logic                              out_compare_true,
  output logic                              out_divide_by_zero
);
  import fpa_pkg::*;

  localparam int DW = DATA_W + FRACTION_BITS;

  logic              adv;
  logic              vld_c  [0:DW];
  side_t             side_c [0:DW];
  logic [DATA_W-1:0] dvsr_c [0:DW];
  logic [DW-1:0]     dvd_c  [0:DW];
  logic [DATA_W-1:0] rem_c  [0:DW];
  logic [DATA_W-1:0] quo_c  [0:DW];

  logic [DATA_W-1:0] quo_signed;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] res_r, res_nxt;
  logic              cmp_r;
  logic              dz_r;

  // Whole pipeline moves unless a finished item is waiting
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  fpa_prep #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_prep (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .in_valid     (in_valid),
    .in_mode      (in_mode),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .prep_valid   (vld_c[0]),
    .prep_side    (side_c[0]),
    .prep_dvsr    (dvsr_c[0]),
    .prep_dvd     (dvd_c[0])
  );

  assign rem_c[0] = '0;
  assign quo_c[0] = '0;

  // Division chain, one quotient bit per cell
  for (genvar i = 0; i < DW; i++) begin : g_cell
    fpa_div_cell #(
      .DW (DW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .in_vld   (vld_c[i]),
      .in_side  (side_c[i]),
      .in_dvsr  (dvsr_c[i]),
      .in_dvd   (dvd_c[i]),
      .in_rem   (rem_c[i]),
      .in_quo   (quo_c[i]),
      .out_vld  (vld_c[i+1]),
      .out_side (side_c[i+1]),
      .out_dvsr (dvsr_c[i+1]),
      .out_dvd  (dvd_c[i+1]),
      .out_rem  (rem_c[i+1]),
      .out_quo  (quo_c[i+1])
    );
  end

  // Apply the quotient sign and pick the final result
  assign quo_signed = side_c[DW].neg ? DATA_W'(-quo_c[DW]) : quo_c[DW];

  always_comb begin
    res_nxt = side_c[DW].res;
    if (side_c[DW].is_div) begin
      res_nxt = side_c[DW].dz ? '0 : quo_signed;
    end
  end

  assign out_valid_nxt = adv ? vld_c[DW] : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
      cmp_r <= side_c[DW].cmp;
      dz_r  <= side_c[DW].dz && side_c[DW].is_div;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_value   = res_r;
  assign out_compare_true   = cmp_r;
  assign out_divide_by_zero = dz_r;

  // A divide by zero always returns zero
  a_dz_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_by_zero |-> out_result_value == '0)
    else $error("divide by zero with nonzero result");

  // Compare and divide-by-zero flags never come together
  a_flags_excl : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_compare_true && out_divide_by_zero))
    else $error("compare and divide-by-zero flags both set");

  // A true comparison carries a zero result value
  a_cmp_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_compare_true |-> out_result_value == '0)
    else $error("comparison with nonzero result");

  // A stalled result is held and stays valid until it is taken
  a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

endmodule

// ===== rtl/fpa_prep.sv =====
module fpa_prep #(
  parameter int FRACTION_BITS = fpa_pkg::FRACTION_BITS_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            adv,
  input  logic                                            in_valid,
  input  logic [3:0]                                      in_mode,
  input  logic signed [fpa_pkg::DATA_W-1:0]               in_operand_a,
  input  logic signed [fpa_pkg::DATA_W-1:0]               in_operand_b,
  output logic                                            prep_valid,
  output fpa_pkg::side_t                                  prep_side,
  output logic [fpa_pkg::DATA_W-1:0]                      prep_dvsr,
  output logic [fpa_pkg::DATA_W+FRACTION_BITS-1:0]        prep_dvd
);
  import fpa_pkg::*;

  localparam int PW = DATA_W + FRACTION_BITS;

  mode_t                    mode;
  logic                     a_lt_b;
  logic                     b_lt_a;
  logic signed [2*DATA_W-1:0] prod;

  logic                     valid_r, valid_nxt;
  side_t                    side_r, side_nxt;
  logic                     mul_r, mul_nxt;
  logic [PW-1:0]            prod_r, prod_nxt;
  logic [DATA_W-1:0]        ma_r, ma_nxt;
  logic [DATA_W-1:0]        mb_r, mb_nxt;

  assign mode   = mode_t'(in_mode);
  assign a_lt_b = in_operand_a < in_operand_b;
  assign b_lt_a = in_operand_b < in_operand_a;
  assign prod   = in_operand_a * in_operand_b;

  // Decode the mode and form the result of every mode but mul and div
  always_comb begin
    side_nxt        = '0;
    mul_nxt         = 1'b0;
    prod_nxt        = prod[PW-1:0];
    ma_nxt          = in_operand_a[DATA_W-1] ? DATA_W'(-in_operand_a) : in_operand_a;
    mb_nxt          = in_operand_b[DATA_W-1] ? DATA_W'(-in_operand_b) : in_operand_b;
    side_nxt.neg    = in_operand_a[DATA_W-1] ^ in_operand_b[DATA_W-1];
    unique case (mode)
      MODE_ADD:      side_nxt.res = in_operand_a + in_operand_b;
      MODE_SUB:      side_nxt.res = in_operand_a - in_operand_b;
      MODE_MUL:      mul_nxt      = 1'b1;
      MODE_DIV: begin
        side_nxt.is_div = 1'b1;
        side_nxt.dz     = (in_operand_b == '0);
      end
      MODE_GT:       side_nxt.cmp = b_lt_a;
      MODE_LT:       side_nxt.cmp = a_lt_b;
      MODE_GE:       side_nxt.cmp = !a_lt_b;
      MODE_LE:       side_nxt.cmp = !b_lt_a;
      MODE_EQ:       side_nxt.cmp = (in_operand_a == in_operand_b);
      MODE_NE:       side_nxt.cmp = (in_operand_a != in_operand_b);
      MODE_MIN:      side_nxt.res = a_lt_b ? in_operand_a : in_operand_b;
      MODE_MAX:      side_nxt.res = b_lt_a ? in_operand_a : in_operand_b;
      MODE_INC:      side_nxt.res = in_operand_a + DATA_W'(1);
      MODE_DEC:      side_nxt.res = in_operand_a - DATA_W'(1);
      MODE_TO_INT:   side_nxt.res = in_operand_a >>> FRACTION_BITS;
      MODE_FROM_INT: side_nxt.res = in_operand_a << FRACTION_BITS;
      default:       side_nxt.res = '0;
    endcase
  end

  assign valid_nxt = adv ? in_valid : valid_r;

  // Hold the stage while the pipeline is stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r <= side_nxt;
      mul_r  <= mul_nxt;
      prod_r <= prod_nxt;
      ma_r   <= ma_nxt;
      mb_r   <= mb_nxt;
    end
  end

  // Scale the product back and widen the dividend
  always_comb begin
    prep_side = side_r;
    if (mul_r) begin
      prep_side.res = prod_r[PW-1:FRACTION_BITS];
    end
  end

  assign prep_valid = valid_r;
  assign prep_dvsr  = mb_r;
  assign prep_dvd   = {ma_r, {FRACTION_BITS{1'b0}}};

endmodule

// ===== rtl/fpa_div_cell.sv =====
module fpa_div_cell #(
  parameter int DW = fpa_pkg::DATA_W + fpa_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          in_vld,
  input  fpa_pkg::side_t                in_side,
  input  logic [fpa_pkg::DATA_W-1:0]    in_dvsr,
  input  logic [DW-1:0]                 in_dvd,
  input  logic [fpa_pkg::DATA_W-1:0]    in_rem,
  input  logic [fpa_pkg::DATA_W-1:0]    in_quo,
  output logic                          out_vld,
  output fpa_pkg::side_t                out_side,
  output logic [fpa_pkg::DATA_W-1:0]    out_dvsr,
  output logic [DW-1:0]                 out_dvd,
  output logic [fpa_pkg::DATA_W-1:0]    out_rem,
  output logic [fpa_pkg::DATA_W-1:0]    out_quo
);
  import fpa_pkg::*;

  logic [DATA_W:0]   rem_sh;
  logic [DATA_W+1:0] diff;
  logic              fits;

  logic              vld_r, vld_nxt;
  side_t             side_r;
  logic [DATA_W-1:0] dvsr_r;
  logic [DW-1:0]     dvd_r, dvd_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] quo_r, quo_nxt;

  // One restoring step: bring in the next dividend bit, try the subtract
  assign rem_sh  = {in_rem, in_dvd[DW-1]};
  assign diff    = {1'b0, rem_sh} - {2'b00, in_dvsr};
  assign fits    = !diff[DATA_W+1];
  assign rem_nxt = fits ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
  assign quo_nxt = {in_quo[DATA_W-2:0], fits};
  assign dvd_nxt = {in_dvd[DW-2:0], 1'b0};
  assign vld_nxt = adv ? in_vld : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Advance the item to the next cell
  always_ff @(posedge clk) begin
    if (adv) begin
      side_r <= in_side;
      dvsr_r <= in_dvsr;
      dvd_r  <= dvd_nxt;
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_side = side_r;
  assign out_dvsr = dvsr_r;
  assign out_dvd  = dvd_r;
  assign out_rem  = rem_r;
  assign out_quo  = quo_r;

endmodule

// ===== verif/tb.sv =====
module tb;
  import fpa_pkg::*;

  localparam int FB          = FRACTION_BITS_DEF;
  localparam int NUM_RANDOM  = 930;
  localparam int DRAIN_WAIT  = 34 + FB + 20;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_AT     = 200;
  localparam int HOLD_LEN    = 300;
  localparam int CALM_LO     = 450;
  localparam int CALM_HI     = 650;

  // One result item of the ALU
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              cmp;
    logic              dz;
  } alu_out_t;

  // One row of the directed table; want is used only where known is set
  typedef struct packed {
    mode_t             mode;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic              known;
    alu_out_t          want;
  } vec_t;

  localparam alu_out_t NONE = '0;
  localparam int NUM_VECS = 24;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [3:0] in_mode = '0;
  logic signed [DATA_W-1:0] in_operand_a = '0;
  logic signed [DATA_W-1:0] in_operand_b = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DATA_W-1:0] out_result_value;
  logic out_compare_true;
  logic out_divide_by_zero;

  alu_out_t pending_results[$];
  int items_sent = 0;
  int results_checked = 0;
  int div_zero_seen = 0;
  int errors = 0;
  int cycle_count = 0;
  bit hold_done = 1'b0;

  vec_t vecs [NUM_VECS] = '{
    '{MODE_ADD,      32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b0}},
    '{MODE_ADD,      32'h7FFF_FFFF, 32'h0000_0001, 1'b1, '{32'h8000_0000, 1'b0, 1'b0}},
    '{MODE_SUB,      32'h8000_0000, 32'h0000_0001, 1'b1, '{32'h7FFF_FFFF, 1'b0, 1'b0}},
    '{MODE_MUL,      32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, NONE},
    '{MODE_MUL,      32'h8000_0000, 32'h8000_0000, 1'b0, NONE},
    '{MODE_MUL,      32'hFFFF_FFFF, 32'h0000_0001, 1'b0, NONE},
    '{MODE_DIV,      32'h0000_0100, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b1}},
    '{MODE_DIV,      32'h8000_0000, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b1}},
    '{MODE_DIV,      32'h8000_0000, 32'hFFFF_FFFF, 1'b0, NONE},
    '{MODE_DIV,      32'hFFFF_FFFD, 32'h0000_0200, 1'b0, NONE},
    '{MODE_GT,       32'h7FFF_FFFF, 32'h8000_0000, 1'b1, '{32'h0000_0000, 1'b1, 1'b0}},
    '{MODE_LT,       32'h7FFF_FFFF, 32'h8000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b0}},
    '{MODE_GE,       32'h0000_0005, 32'h0000_0005, 1'b1, '{32'h0000_0000, 1'b1, 1'b0}},
    '{MODE_LE,       32'h8000_0000, 32'h8000_0000, 1'b1, '{32'h0000_0000, 1'b1, 1'b0}},
    '{MODE_EQ,       32'h1234_5678, 32'h1234_5678, 1'b1, '{32'h0000_0000, 1'b1, 1'b0}},
    '{MODE_NE,       32'h1234_5678, 32'h1234_5678, 1'b1, '{32'h0000_0000, 1'b0, 1'b0}},
    '{MODE_MIN,      32'h8000_0000, 32'h7FFF_FFFF, 1'b1, '{32'h8000_0000, 1'b0, 1'b0}},
    '{MODE_MAX,      32'h8000_0000, 32'h7FFF_FFFF, 1'b1, '{32'h7FFF_FFFF, 1'b0, 1'b0}},
    '{MODE_INC,      32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'h8000_0000, 1'b0, 1'b0}},
    '{MODE_DEC,      32'h8000_0000, 32'h0000_0000, 1'b1, '{32'h7FFF_FFFF, 1'b0, 1'b0}},
    '{MODE_TO_INT,   32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, 1'b0, 1'b0}},
    '{MODE_TO_INT,   32'hFFFF_FF80, 32'h0000_0000, 1'b0, NONE},
    '{MODE_FROM_INT, 32'h0080_0000, 32'h0000_0000, 1'b0, NONE},
    '{MODE_FROM_INT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, NONE}
  };

  fixed_point_alu_unit #(.FRACTION_BITS(FB)) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_operand_a      (in_operand_a),
    .in_operand_b      (in_operand_b),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_value  (out_result_value),
    .out_compare_true  (out_compare_true),
    .out_divide_by_zero(out_divide_by_zero)
  );

  // Compute the ALU result of one item
  function automatic alu_out_t alu_result(mode_t mode, logic signed [DATA_W-1:0] a,
                                          logic signed [DATA_W-1:0] b);
    logic signed [63:0] wa;
    logic signed [63:0] wb;
    logic signed [63:0] wide;
    logic [63:0] mag_a;
    logic [63:0] mag_b;
    logic [63:0] quot;
    alu_out_t r;
    r = '0;
    wa = a;
    wb = b;
    case (mode)
      MODE_ADD: r.value = a + b;
      MODE_SUB: r.value = a - b;
      MODE_MUL: begin
        wide = (wa * wb) >>> FB;
        r.value = wide[DATA_W-1:0];
      end
      MODE_DIV: begin
        if (b == 0) begin
          r.dz = 1'b1;
        end else begin
          mag_a = a[DATA_W-1] ? -wa : wa;
          mag_b = b[DATA_W-1] ? -wb : wb;
          quot = (mag_a << FB) / mag_b;
          if (a[DATA_W-1] ^ b[DATA_W-1]) quot = -quot;
          r.value = quot[DATA_W-1:0];
        end
      end
      MODE_GT: r.cmp = a > b;
      MODE_LT: r.cmp = a < b;
      MODE_GE: r.cmp = a >= b;
      MODE_LE: r.cmp = a <= b;
      MODE_EQ: r.cmp = a == b;
      MODE_NE: r.cmp = a != b;
      MODE_MIN: r.value = (a < b) ? a : b;
      MODE_MAX: r.value = (a > b) ? a : b;
      MODE_INC: r.value = a + 32'sd1;
      MODE_DEC: r.value = a - 32'sd1;
      MODE_TO_INT: r.value = a >>> FB;
      default: r.value = a << FB;
    endcase
    return r;
  endfunction

  // Pick an operand: mostly full range, with extremes, small and shifted 16-bit values mixed in
  function automatic logic [DATA_W-1:0] pick_operand();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: v = 32'h0000_0000;
          1: v = 32'h0000_0001;
          2: v = 32'hFFFF_FFFF;
          3: v = 32'h8000_0000;
          default: v = 32'h7FFF_FFFF;
        endcase
      end
      1: v = $urandom_range(0, 1023) - 512;
      2: v = ($urandom_range(0, 65535) - 32768) << $urandom_range(0, 8);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Offer one item and hold it until accepted; call at a rising edge
  task automatic push_item(mode_t mode, logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
                           alu_out_t want);
    in_valid     <= 1'b1;
    in_mode      <= mode;
    in_operand_a <= a;
    in_operand_b <= b;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    pending_results.push_back(want);
    items_sent++;
  endtask

  // Clock
  initial begin
    forever #1 clk = ~clk;
  end

  // Cycle counter and timeout
  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("timeout at %0t with %0d results outstanding", $time,
                 pending_results.size());
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Receiver: random stalls, one long hold-off, a calm stretch
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (!hold_done && items_sent >= HOLD_AT) begin
        out_ready <= 1'b0;
        hold_left = HOLD_LEN - 1;
        hold_done = 1'b1;
      end else if (items_sent >= CALM_LO && items_sent < CALM_HI) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 16);
      end
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(negedge clk) begin
    alu_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result value=%h cmp=%b dz=%b", $time,
                 out_result_value, out_compare_true, out_divide_by_zero);
        errors++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_divide_by_zero) div_zero_seen++;
        if (out_result_value !== want.value) begin
          $display("%0t: result_value expected %h actual %h", $time, want.value,
                   out_result_value);
          errors++;
        end
        if (out_compare_true !== want.cmp) begin
          $display("%0t: compare_true expected %b actual %b", $time, want.cmp,
                   out_compare_true);
          errors++;
        end
        if (out_divide_by_zero !== want.dz) begin
          $display("%0t: divide_by_zero expected %b actual %b", $time, want.dz,
                   out_divide_by_zero);
          errors++;
        end
      end
    end
  end

  // Reset, directed table, random items, drain
  initial begin
    mode_t mode;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    alu_out_t want;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    for (int i = 0; i < NUM_VECS; i++) begin
      want = vecs[i].known ? vecs[i].want : alu_result(vecs[i].mode, vecs[i].a, vecs[i].b);
      push_item(vecs[i].mode, vecs[i].a, vecs[i].b, want);
    end

    // Random items with random gaps, none in the calm stretch
    for (int i = 0; i < NUM_RANDOM; i++) begin
      while (!(items_sent >= CALM_LO && items_sent < CALM_HI) &&
             $urandom_range(0, 99) < 16) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      mode = mode_t'($urandom_range(0, 15));
      a = pick_operand();
      b = pick_operand();
      if (mode == MODE_DIV && $urandom_range(0, 9) == 0) b = '0;
      if (mode >= MODE_GT && mode <= MODE_MAX && $urandom_range(0, 4) == 0) b = a;
      push_item(mode, a, b, alu_result(mode, a, b));
    end
    in_valid <= 1'b0;

    // Drain, then watch for stray results
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("%0d items sent over all 16 modes, %0d results checked, %0d divide by zero",
             items_sent, results_checked, div_zero_seen);
    $display("output held off for %0d cycles once; %0d mismatches", HOLD_LEN, errors);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/fpa_pkg.sv
rtl/fpa_prep.sv
rtl/fpa_div_cell.sv
rtl/fixed_point_alu_unit.sv
verif/tb.sv
